>>> design/ipg_pkg.sv
// Shared types, constants and codes of the image patch gather block.
`default_nettype none

package ipg_pkg;

  // Default sizes of the pixel store and of the samples.
  localparam int IMG_ROWS_DEF    = 64;
  localparam int IMG_COLS_DEF    = 64;
  localparam int MAX_PATCH_DEF   = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths of the transaction payloads and registers.
  localparam int COORD_W  = 6;
  localparam int FIELD_W  = 16;
  localparam int IDX_W    = 6;
  localparam int SIZE_W   = 4;
  localparam int STEP_W   = 7;
  localparam int GRID_W   = 7;
  localparam int ORIGIN_W = COORD_W + STEP_W;

  // Register port.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_PATCH = 1'b1
  } mode_t;

  typedef enum logic {
    ORDER_COLOR = 1'b0,
    ORDER_DEPTH = 1'b1
  } order_t;

  typedef enum logic [2:0] {
    REG_PATCH_WIDTH   = 3'd0,
    REG_PATCH_HEIGHT  = 3'd1,
    REG_STEP_X        = 3'd2,
    REG_STEP_Y        = 3'd3,
    REG_GRID_WIDTH    = 3'd4,
    REG_GRID_HEIGHT   = 3'd5,
    REG_CHANNEL_ORDER = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_ERROR,
    S_WALK
  } seq_state_t;

  typedef struct packed {
    mode_t                mode;
    logic [COORD_W-1:0]   pixel_row;
    logic [COORD_W-1:0]   pixel_col;
    logic [FIELD_W-1:0]   gray_in;
    logic [FIELD_W-1:0]   chan_zero;
    logic [FIELD_W-1:0]   chan_one;
    logic [FIELD_W-1:0]   chan_two;
    logic [COORD_W-1:0]   patch_i;
    logic [COORD_W-1:0]   patch_j;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]     element_index;
    logic [FIELD_W-1:0]   gray_out;
    logic [FIELD_W-1:0]   plane_a;
    logic [FIELD_W-1:0]   plane_b;
    logic [FIELD_W-1:0]   plane_c;
    logic                 status;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [SIZE_W-1:0]    patch_width;
    logic [SIZE_W-1:0]    patch_height;
    logic [STEP_W-1:0]    step_x;
    logic [STEP_W-1:0]    step_y;
    logic [GRID_W-1:0]    grid_width;
    logic [GRID_W-1:0]    grid_height;
    order_t               channel_order;
  } cfg_t;

  // Metadata of one issued pixel read, to be aligned with the read data in the cycle after the read.
  typedef struct packed {
    logic                 valid;
    logic [IDX_W-1:0]     idx;
    logic                 last;
  } issue_t;

  // Space in the result queue, as seen by the sequencer.
  typedef struct packed {
    logic                 issue_ok;
    logic                 err_ok;
  } room_t;

endpackage

`default_nettype wire

>>> design/ipg_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ipg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/ipg_seq.sv
// Sequencer: pixel writes, patch range check and the walk over the patch's pixels.
`default_nettype none

module ipg_seq #(
  parameter int IMG_ROWS    = 64,
  parameter int IMG_COLS    = 64,
  parameter int MAX_PATCH   = 8,
  parameter int SAMPLE_BITS = 16,
  localparam int ADDR_W = $clog2(IMG_ROWS * IMG_COLS),
  localparam int MEM_W  = 4 * SAMPLE_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ipg_pkg::cfg_t      cfg,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire ipg_pkg::item_t     item,
  input  wire ipg_pkg::room_t     room,
  output logic                    wr_en,
  output logic      [ADDR_W-1:0]  wr_addr,
  output logic      [MEM_W-1:0]   wr_data,
  output logic                    rd_en,
  output logic      [ADDR_W-1:0]  rd_addr,
  output ipg_pkg::issue_t         issue,
  output logic                    err_push
);

  import ipg_pkg::*;

  localparam int ROW_W = $clog2(IMG_ROWS);
  localparam int COL_W = $clog2(IMG_COLS);

  seq_state_t state, state_next;

  logic [COORD_W-1:0]  pi, pj;
  logic [ORIGIN_W-1:0] x0, y0;
  logic [SIZE_W-1:0]   lx, my;
  logic [IDX_W-1:0]    idx;

  logic                accept;
  logic                bad;
  logic                x_end, y_end, walk_last;
  logic [ORIGIN_W-1:0] row_sum, col_sum;

  assign accept = item_valid && item_ready;

  // Pixel writes go straight to the store in the cycle they are accepted.
  assign wr_en   = accept && (item.mode == MODE_WRITE)
                && (int'(item.pixel_row) < IMG_ROWS) && (int'(item.pixel_col) < IMG_COLS);
  assign wr_addr = ADDR_W'(item.pixel_row) * ADDR_W'(IMG_COLS) + ADDR_W'(item.pixel_col);
  assign wr_data = {item.chan_two[SAMPLE_BITS-1:0], item.chan_one[SAMPLE_BITS-1:0],
                    item.chan_zero[SAMPLE_BITS-1:0], item.gray_in[SAMPLE_BITS-1:0]};

  assign bad = (cfg.patch_width == '0) || (int'(cfg.patch_width) > MAX_PATCH)
            || (cfg.patch_height == '0) || (int'(cfg.patch_height) > MAX_PATCH)
            || (GRID_W'(pi) >= cfg.grid_width) || (GRID_W'(pj) >= cfg.grid_height)
            || (int'(x0) + int'(cfg.patch_width) > IMG_ROWS)
            || (int'(y0) + int'(cfg.patch_height) > IMG_COLS);

  assign x_end     = (SIZE_W'(lx + 1'b1) == cfg.patch_width);
  assign y_end     = (SIZE_W'(my + 1'b1) == cfg.patch_height);
  assign walk_last = x_end && y_end;

  assign row_sum = x0 + ORIGIN_W'(lx);
  assign col_sum = y0 + ORIGIN_W'(my);
  assign rd_addr = ADDR_W'(row_sum[ROW_W-1:0]) * ADDR_W'(IMG_COLS)
                 + ADDR_W'(col_sum[COL_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    rd_en      = 1'b0;
    err_push   = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid && item.mode == MODE_PATCH) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = bad ? S_ERROR : S_WALK;
      end
      S_ERROR: begin
        err_push = room.err_ok;
        if (room.err_ok) begin
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        rd_en = room.issue_ok;
        if (room.issue_ok && walk_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign issue.valid = rd_en;
  assign issue.idx   = idx;
  assign issue.last  = walk_last;

  // Patch origin and walk counters; the x offset runs fastest.
  always_ff @(posedge clk) begin
    if (accept) begin
      pi  <= item.patch_i;
      pj  <= item.patch_j;
      x0  <= ORIGIN_W'(item.patch_i) * ORIGIN_W'(cfg.step_x);
      y0  <= ORIGIN_W'(item.patch_j) * ORIGIN_W'(cfg.step_y);
      lx  <= '0;
      my  <= '0;
      idx <= '0;
    end else if (rd_en) begin
      idx <= IDX_W'(idx + 1'b1);
      if (x_end) begin
        lx <= '0;
        my <= SIZE_W'(my + 1'b1);
      end else begin
        lx <= SIZE_W'(lx + 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/ipg_outq.sv
// Result queue: aligns read data with its metadata and holds up to two results.
`default_nettype none

module ipg_outq #(
  parameter int SAMPLE_BITS = 16,
  localparam int MEM_W = 4 * SAMPLE_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ipg_pkg::order_t    order,
  input  wire ipg_pkg::issue_t    issue,
  input  wire logic [MEM_W-1:0]   rd_data,
  input  wire logic               err_push,
  output ipg_pkg::room_t          room,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output ipg_pkg::result_t        result
);

  import ipg_pkg::*;

  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic             pend_last;

  result_t          ent [2];
  logic             wptr, rptr;
  logic [1:0]       cnt;

  logic             push, pop;
  result_t          push_item;
  logic [FIELD_W-1:0] s_gray, s_c0, s_c1, s_c2;

  assign s_gray = FIELD_W'(rd_data[SAMPLE_BITS-1:0]);
  assign s_c0   = FIELD_W'(rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
  assign s_c1   = FIELD_W'(rd_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
  assign s_c2   = FIELD_W'(rd_data[4*SAMPLE_BITS-1:3*SAMPLE_BITS]);

  always_comb begin
    if (pend) begin
      push_item.element_index = pend_idx;
      push_item.gray_out      = s_gray;
      push_item.plane_a       = (order == ORDER_COLOR) ? s_c2 : s_c0;
      push_item.plane_b       = s_c1;
      push_item.plane_c       = (order == ORDER_COLOR) ? s_c0 : s_c2;
      push_item.status        = 1'b0;
      push_item.last          = pend_last;
    end else begin
      push_item        = '0;
      push_item.status = 1'b1;
      push_item.last   = 1'b1;
    end
  end

  assign push         = pend || err_push;
  assign result_valid = (cnt != 2'd0);
  assign pop          = result_valid && result_ready;
  assign result       = ent[rptr];

  // A read may be issued when the queue plus the read in flight stays within two.
  assign room.issue_ok = (3'(cnt) + 3'(pend)) < (3'd2 + 3'(pop));
  assign room.err_ok   = (cnt == 2'd0) && !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      cnt  <= 2'd0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      pend <= issue.valid;
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   cnt <= 2'(cnt + 1'b1);
        2'b01:   cnt <= 2'(cnt - 1'b1);
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pend_idx  <= issue.idx;
    pend_last <= issue.last;
    if (push) begin
      ent[wptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> design/image_patch_gather.sv
// Top level of the image patch gather block: register port, pixel store and result path.
`default_nettype none

// The block keeps a pixel store of IMG_ROWS x IMG_COLS entries, each holding a
// gray (or depth) sample and three channel samples, in one simple dual-port RAM
// with a registered read. A write transaction (mode 0) stores one pixel in the
// cycle it is accepted and produces no result; writes outside the store are
// dropped. A patch transaction (mode 1) has its origin registered on acceptance
// and is then checked against the grid and the store edges; a bad request then
// gives a single error result (status and last set, all else zero). A good
// request walks the patch with the x offset varying fastest, issuing one read of
// the store's single read port per cycle while the result queue has room.
// Results pass through a two-entry queue, so the next transaction is accepted
// while the last results still wait to be taken, and a stalled result side
// pauses the walk without loss. The store needs no clearing after reset;
// reading a pixel that was never written returns whatever the RAM holds.
// Registers sit on an APB-style port at byte addresses 4*i and are meant to
// be written only while the block is idle.

module image_patch_gather #(
  parameter int IMG_ROWS    = ipg_pkg::IMG_ROWS_DEF,
  parameter int IMG_COLS    = ipg_pkg::IMG_COLS_DEF,
  parameter int MAX_PATCH   = ipg_pkg::MAX_PATCH_DEF,
  parameter int SAMPLE_BITS = ipg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ipg_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [ipg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [ipg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  input  wire logic                             item_valid,
  output logic                                  item_ready,
  input  wire ipg_pkg::item_t                   item,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output ipg_pkg::result_t                      result
);

  import ipg_pkg::*;

  localparam int DEPTH  = IMG_ROWS * IMG_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int MEM_W  = 4 * SAMPLE_BITS;

  cfg_t              cfg;
  logic              cfg_write;
  reg_idx_t          reg_sel;

  logic              wr_en, rd_en, err_push;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [MEM_W-1:0]  wr_data, rd_data;
  issue_t            issue;
  room_t             room;

  // The register port never waits; a write lands on the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.patch_width   <= SIZE_W'(5);
      cfg.patch_height  <= SIZE_W'(5);
      cfg.step_x        <= STEP_W'(1);
      cfg.step_y        <= STEP_W'(1);
      cfg.grid_width    <= GRID_W'(60);
      cfg.grid_height   <= GRID_W'(60);
      cfg.channel_order <= ORDER_COLOR;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_PATCH_WIDTH:   cfg.patch_width   <= pwdata[SIZE_W-1:0];
        REG_PATCH_HEIGHT:  cfg.patch_height  <= pwdata[SIZE_W-1:0];
        REG_STEP_X:        cfg.step_x        <= pwdata[STEP_W-1:0];
        REG_STEP_Y:        cfg.step_y        <= pwdata[STEP_W-1:0];
        REG_GRID_WIDTH:    cfg.grid_width    <= pwdata[GRID_W-1:0];
        REG_GRID_HEIGHT:   cfg.grid_height   <= pwdata[GRID_W-1:0];
        REG_CHANNEL_ORDER: cfg.channel_order <= order_t'(pwdata[0]);
        default: ;
      endcase
    end
  end

  // Read-back of the registers; unused addresses read as zero.
  always_comb begin
    case (reg_sel)
      REG_PATCH_WIDTH:   prdata = APB_DATA_W'(cfg.patch_width);
      REG_PATCH_HEIGHT:  prdata = APB_DATA_W'(cfg.patch_height);
      REG_STEP_X:        prdata = APB_DATA_W'(cfg.step_x);
      REG_STEP_Y:        prdata = APB_DATA_W'(cfg.step_y);
      REG_GRID_WIDTH:    prdata = APB_DATA_W'(cfg.grid_width);
      REG_GRID_HEIGHT:   prdata = APB_DATA_W'(cfg.grid_height);
      REG_CHANNEL_ORDER: prdata = {{(APB_DATA_W-1){1'b0}}, cfg.channel_order};
      default:           prdata = '0;
    endcase
  end

  // Sequencer: takes transactions, writes pixels and walks patches.
  ipg_seq #(
    .IMG_ROWS    (IMG_ROWS),
    .IMG_COLS    (IMG_COLS),
    .MAX_PATCH   (MAX_PATCH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .room       (room),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .issue      (issue),
    .err_push   (err_push)
  );

  // Pixel store: gray in the low sample, then channels zero, one and two.
  ipg_ram #(
    .WIDTH (MEM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result queue: reorders the channels and buffers results for the consumer.
  ipg_outq #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_outq (
    .clk          (clk),
    .rst          (rst),
    .order        (cfg.channel_order),
    .issue        (issue),
    .rd_data      (rd_data),
    .err_push     (err_push),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
